/* hdl/skl_pkg.sv */
// ---------------------------------------------------------------------------
// skl_pkg
// Shared types and codes for the sorted key list: operation codes, result
// status codes and the control states of the list sequencer.
// ---------------------------------------------------------------------------
package skl_pkg;

  // Operation requested by an input word
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CHANGE = 2'd2,
    MODE_NONE   = 2'd3
  } skl_mode_t;

  // Status reported with every result word
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } skl_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_FIND,
    S_DEL_SHIFT,
    S_RESULT
  } skl_state_t;

endpackage

/* hdl/skl_ram.sv */
// ---------------------------------------------------------------------------
// skl_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ---------------------------------------------------------------------------
module skl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/sorted_key_list.sv */
// ---------------------------------------------------------------------------
// sorted_key_list
// Ascending list of signed 32-bit keys in one RAM. Insert and delete scan
// and shift one entry per cycle; change-key overwrites in place, no re-sort.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   in_       input      in_valid/in_stall  mode, key, new_key
//   out_      output     out_valid/out_stall status, entry_count, is_full,
//                                           is_empty
//
// One word is in work at a time; the single RAM read port is walked one entry
// per cycle. A word is accepted only in the idle state, which the sequencer
// reenters from the result state once the output register is free.
// Reset (rst_n low, synchronous) empties the list; RAM contents are not
// cleared. A result waits in the output register while out_stall is high,
// and the next word is accepted meanwhile; its own result then holds the
// input stalled until the output register frees.
// ---------------------------------------------------------------------------
module sorted_key_list #(
  parameter int CAPACITY = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_mode,
  input  logic signed [31:0]        in_key,
  input  logic signed [31:0]        in_new_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [5:0]                out_entry_count,
  output logic                      out_is_full,
  output logic                      out_is_empty
);
  import skl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  skl_state_t         state_r, state_nxt;
  skl_mode_t          mode_r, mode_nxt;
  skl_status_t        st_r, st_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] new_key_r, new_key_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      pi_r, pi_nxt;
  logic               pv_r, pv_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [5:0]         out_count_r, out_count_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_empty_r, out_empty_nxt;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  logic               in_acc;
  logic               out_free;
  logic               full;
  logic               empty;
  logic               hit;
  logic               gt;
  logic               more;
  logic [CW:0]        pi_inc;
  logic [CW-1:0]      pi_dec;
  logic [CW-1:0]      pi_dec2;
  logic [CW-1:0]      cnt_dec;
  logic [CW+5:0]      cnt_ext;
  skl_mode_t          in_mode_t;

  // Key store
  skl_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared conditions
  assign in_mode_t = skl_mode_t'(in_mode);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (cnt_r == CW'(CAPACITY));
  assign empty     = (cnt_r == '0);
  assign hit       = (rd_data == key_r);
  assign gt        = ($signed(rd_data) > key_r);
  assign pi_inc    = {1'b0, pi_r} + 1'b1;
  assign pi_dec    = pi_r - 1'b1;
  assign pi_dec2   = pi_r - CW'(2);
  assign cnt_dec   = cnt_r - 1'b1;
  assign more      = (pi_inc < {1'b0, cnt_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_mode_t) inside
            MODE_INSERT: state_nxt = full ? S_RESULT : S_INS_SCAN;
            MODE_DELETE,
            MODE_CHANGE: state_nxt = empty ? S_RESULT : S_FIND;
            default:     state_nxt = S_RESULT;
          endcase
        end
      end
      S_INS_SCAN: begin
        if (!pv_r || !gt) begin
          state_nxt = S_RESULT;
        end
      end
      S_FIND: begin
        if (hit) begin
          state_nxt = (mode_r == MODE_CHANGE) ? S_RESULT : S_DEL_SHIFT;
        end else if (!more) begin
          state_nxt = S_RESULT;
        end
      end
      S_DEL_SHIFT: begin
        if (!pv_r) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    mode_nxt    = mode_r;
    st_nxt      = st_r;
    key_nxt     = key_r;
    new_key_nxt = new_key_r;
    cnt_nxt     = cnt_r;
    pi_nxt      = pi_r;
    pv_nxt      = pv_r;
    wr_en       = 1'b0;
    wr_addr     = pi_r[AW-1:0];
    wr_data     = key_r;
    rd_en       = 1'b0;
    rd_addr     = pi_inc[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Latch the word and start the first read when the list must be scanned
          mode_nxt    = in_mode_t;
          key_nxt     = in_key;
          new_key_nxt = in_new_key;
          st_nxt      = ST_OK;
          unique case (in_mode_t) inside
            MODE_INSERT: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                pi_nxt  = cnt_r;
                pv_nxt  = !empty;
                rd_en   = !empty;
                rd_addr = cnt_dec[AW-1:0];
              end
            end
            MODE_DELETE,
            MODE_CHANGE: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                pi_nxt  = '0;
                pv_nxt  = 1'b1;
                rd_en   = 1'b1;
                rd_addr = '0;
              end
            end
            default: st_nxt = ST_OK;
          endcase
        end
      end
      S_INS_SCAN: begin
        wr_en = 1'b1;
        if (pv_r && gt) begin
          // Move the larger key up one slot and read the next one down
          wr_data = rd_data;
          pi_nxt  = pi_dec;
          pv_nxt  = (pi_r > CW'(1));
          rd_en   = (pi_r > CW'(1));
          rd_addr = pi_dec2[AW-1:0];
        end else begin
          // Drop the new key into the open slot
          wr_data = key_r;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = ST_OK;
        end
      end
      S_FIND: begin
        rd_en   = more;
        rd_addr = pi_inc[AW-1:0];
        pi_nxt  = pi_inc[CW-1:0];
        pv_nxt  = more;
        if (hit) begin
          st_nxt = ST_OK;
          if (mode_r == MODE_CHANGE) begin
            wr_en   = 1'b1;
            wr_data = new_key_r;
          end
        end else if (!more) begin
          st_nxt = ST_MISSING;
        end
      end
      S_DEL_SHIFT: begin
        if (pv_r) begin
          // Close the gap: move the entry down one slot
          wr_en   = 1'b1;
          wr_addr = pi_dec[AW-1:0];
          wr_data = rd_data;
          rd_en   = more;
          rd_addr = pi_inc[AW-1:0];
          pi_nxt  = pi_inc[CW-1:0];
          pv_nxt  = more;
        end else begin
          cnt_nxt = cnt_dec;
        end
      end
      S_RESULT: begin
        pv_nxt = 1'b0;
      end
      default: pv_nxt = 1'b0;
    endcase
  end

  // Output register
  assign cnt_ext = {6'b0, cnt_r};

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_full_nxt   = out_full_r;
    out_empty_nxt  = out_empty_r;
    if (state_r == S_RESULT && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = st_r;
      out_count_nxt  = cnt_ext[5:0];
      out_full_nxt   = full;
      out_empty_nxt  = empty;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    st_r         <= st_nxt;
    key_r        <= key_nxt;
    new_key_r    <= new_key_nxt;
    pi_r         <= pi_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_full_r   <= out_full_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_is_full     = out_full_r;
  assign out_is_empty    = out_empty_r;

endmodule
